// ===== rtl/wssim_pkg.sv =====
package wssim_pkg;

  // Input item operations
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_PATCH_RADIUS   = 3'd2;
  localparam logic [2:0] REG_STAB_C1        = 3'd3;
  localparam logic [2:0] REG_STAB_C2        = 3'd4;
  localparam logic [2:0] REG_CLAMP_NEGATIVE = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 40;

  // Register reset values
  localparam logic [10:0] RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [10:0] RST_IMAGE_HEIGHT   = 11'd1024;
  localparam logic [1:0]  RST_PATCH_RADIUS   = 2'd2;
  localparam logic [39:0] RST_STAB_C1        = 40'd1665;
  localparam logic [39:0] RST_STAB_C2        = 40'd14982;
  localparam logic        RST_CLAMP_NEGATIVE = 1'b0;

  // 1.0 in Q2.14 and the number of quotient bits per division
  localparam logic [14:0] ONE_Q14   = 15'd16384;
  localparam logic [3:0]  DIV_STEPS = 4'd15;

  typedef struct packed {
    logic        operation;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] ssim_value;
    logic               frame_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_INIT,
    ST_WALK_ADDR,
    ST_WALK_M0,
    ST_WALK_M1,
    ST_WALK_M2,
    ST_WALK_M3,
    ST_MUL,
    ST_CALC0,
    ST_CALC1,
    ST_CALC2,
    ST_DIV_CHK,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Multiply steps of the shared 32x32 unit, in issue order
  typedef enum logic [4:0] {
    MS_SQ_N,
    MS_C1_LO,
    MS_C1_HI,
    MS_C2_LO,
    MS_C2_HI,
    MS_SA_SB,
    MS_SA_SA,
    MS_SB_SB,
    MS_NSAA_LO,
    MS_NSAA_HI,
    MS_NSBB_LO,
    MS_NSBB_HI,
    MS_NSAB_LO,
    MS_NSAB_HI,
    MS_NUM_LL,
    MS_NUM_LH,
    MS_NUM_HL,
    MS_NUM_HH,
    MS_DEN_LL,
    MS_DEN_LH,
    MS_DEN_HL,
    MS_DEN_HH
  } mul_step_t;

endpackage

// ===== rtl/windowed_ssim_image_compare.sv =====
// Channel | Signals                      | Transfer when
// --------+------------------------------+---------------------------------------
// in      | in_valid, in_ready, in_item  | in_valid & in_ready at rising clk
// out     | out_valid, out_ready, out_item | out_valid & out_ready at rising clk
// cfg     | cfg_write, cfg_index, cfg_data | cfg_write at rising clk, no wait
//
// An item that yields no result leaves the block idle. An item that yields a result
// walks the (2r+1)^2 square, an address state per cell and states M0 to M3 per cell
// inside disc and image, then runs the multiply steps, the calc states, a divide
// check, the divide if needed and finish, all with a single 32x32 multiplier.
// rst is synchronous; it clears positions, pending count and out_valid, resets cfg.
// in_ready is low while a result is computed; a finished result waiting in the output
// register does not block the next input transfer, only the next result.
module windowed_ssim_image_compare #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_RADIUS  = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wssim_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output wssim_pkg::out_item_t                 out_item,
  input  logic                                 cfg_write,
  input  logic [wssim_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wssim_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LC      = 2 * MAX_RADIUS + 2;
  localparam int LINE_W  = $clog2(LC);
  localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int DW      = RW + 1;
  localparam int CELLS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int S1_W    = SAMPLE_BITS + CNT_W;
  localparam int S2_W    = 2 * SAMPLE_BITS + CNT_W;
  localparam int IW      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int DEPTH   = LC * MAX_WIDTH;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int STORE_W = 2 * SAMPLE_BITS;

  typedef struct packed {
    logic [XW-1:0]     col;
    logic [YW-1:0]     row;
    logic [LINE_W-1:0] line;
  } pos_t;

  // Move to the start of the next row; the ring line always advances.
  function automatic pos_t next_row(pos_t p, logic [HW-1:0] h);
    pos_t q;
    q      = p;
    q.col  = '0;
    q.line = (32'(p.line) == LC - 1) ? '0 : LINE_W'(32'(p.line) + 1);
    q.row  = (32'(p.row) + 1 >= 32'(h)) ? '0 : YW'(32'(p.row) + 1);
    return q;
  endfunction

  // Wrap a position that a shrunk geometry left outside the image.
  function automatic pos_t norm_pos(pos_t p, logic [WW-1:0] w, logic [HW-1:0] h);
    pos_t q;
    q = p;
    if (32'(q.col) >= 32'(w)) begin
      q = next_row(q, h);
    end
    if (32'(q.row) >= 32'(h)) begin
      q.row = '0;
    end
    return q;
  endfunction

  function automatic pos_t adv_pos(pos_t p, logic [WW-1:0] w, logic [HW-1:0] h);
    pos_t q;
    q = p;
    if (32'(p.col) + 1 >= 32'(w)) begin
      q = next_row(p, h);
    end else begin
      q.col = XW'(32'(p.col) + 1);
    end
    return q;
  endfunction

  // Configuration registers
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [1:0]  patch_radius;
  logic [39:0] stab_c1;
  logic [39:0] stab_c2;
  logic        clamp_negative;

  // Control state
  wssim_pkg::state_t    state, state_next;
  wssim_pkg::mul_step_t step;
  logic                 mul_ph;
  pos_t                 in_pos;
  pos_t                 out_pos;
  logic [IW-1:0]        items_seen;
  logic signed [DW-1:0] dx, dy;
  logic [3:0]           div_cnt;

  // Window sums
  logic [CNT_W-1:0] n;
  logic [S1_W-1:0]  sa, sb;
  logic [S2_W-1:0]  saa, sbb, sab;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Ratio terms; the 64-bit ones are kept modulo 2^64 as the arithmetic defines them
  logic [63:0]  nn, c1n, c2n, q, sasa, sbsb, nsaa, nsbb, p;
  logic [63:0]  f1n, f1d, f2n, f2d, va, vb, diff;
  logic         pos_cov, neg;
  logic [127:0] num, den;
  logic [14:0]  quo, mag;

  logic [STORE_W-1:0] store_mem [DEPTH];
  logic [STORE_W-1:0] rd_data;

  // Effective geometry
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] eff_r;
  logic [IW-1:0] thr;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
    if (32'(patch_radius) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(patch_radius);
    end
    thr = IW'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
  end

  // Input side: normalized write position and whether this item emits
  pos_t              in_norm;
  logic              emit_now;
  logic [ADDR_W-1:0] wr_addr;

  always_comb begin
    in_norm = norm_pos(in_pos, eff_w, eff_h);
    wr_addr = ADDR_W'(32'(in_norm.line) * MAX_WIDTH + 32'(in_norm.col));
    if (in_item.operation == wssim_pkg::OP_DRAIN) begin
      emit_now = (in_norm.col == '0) && (in_norm.row == '0) && (items_seen != '0);
    end else begin
      emit_now = (32'(items_seen) + 1) > 32'(thr);
    end
  end

  // Window cell: disc test, image bounds, ring slot and store address
  logic signed [DW-1:0]     r_s;
  logic signed [2*DW-1:0]   dxe, dye, rre;
  logic signed [YW+1:0]     cy;
  logic signed [XW+1:0]     cx;
  logic signed [LINE_W+1:0] slot_raw, slot;
  logic                     cell_ok, last_cell;
  logic [ADDR_W-1:0]        rd_addr;

  always_comb begin
    r_s       = $signed({1'b0, eff_r});
    dxe       = (2*DW)'(dx);
    dye       = (2*DW)'(dy);
    rre       = (2*DW)'(r_s);
    cy        = $signed({2'b00, out_pos.row}) + (YW+2)'(dy);
    cx        = $signed({2'b00, out_pos.col}) + (XW+2)'(dx);
    slot_raw  = $signed({2'b00, out_pos.line}) + (LINE_W+2)'(dy);
    if (slot_raw < 0) begin
      slot = slot_raw + (LINE_W+2)'(LC);
    end else if (slot_raw >= (LINE_W+2)'(LC)) begin
      slot = slot_raw - (LINE_W+2)'(LC);
    end else begin
      slot = slot_raw;
    end
    cell_ok   = (dxe * dxe + dye * dye <= rre * rre)
                && !cy[YW+1] && (32'(cy) < 32'(eff_h))
                && !cx[XW+1] && (32'(cx) < 32'(eff_w));
    rd_addr   = ADDR_W'(32'(slot) * MAX_WIDTH + 32'(cx[XW-1:0]));
    last_cell = (dx == r_s) && (dy == r_s);
  end

  logic [SAMPLE_BITS-1:0] px_a, px_b;
  logic [63:0]            saa64, sbb64, sab64;
  logic                   div_ge;
  logic [127:0]           num_sh;
  logic [14:0]            quo_next;
  logic                   out_free;

  always_comb begin
    px_a     = rd_data[SAMPLE_BITS-1:0];
    px_b     = rd_data[STORE_W-1:SAMPLE_BITS];
    saa64    = 64'(saa);
    sbb64    = 64'(sbb);
    sab64    = 64'(sab);
    num_sh   = {num[126:0], 1'b0};
    div_ge   = num_sh >= den;
    quo_next = {quo[13:0], div_ge};
    out_free = !out_valid || out_ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wssim_pkg::ST_IDLE: begin
        if (in_valid && emit_now) begin
          state_next = wssim_pkg::ST_WALK_INIT;
        end
      end
      wssim_pkg::ST_WALK_INIT: state_next = wssim_pkg::ST_WALK_ADDR;
      wssim_pkg::ST_WALK_ADDR: begin
        if (cell_ok) begin
          state_next = wssim_pkg::ST_WALK_M0;
        end else if (last_cell) begin
          state_next = wssim_pkg::ST_MUL;
        end
      end
      wssim_pkg::ST_WALK_M0: state_next = wssim_pkg::ST_WALK_M1;
      wssim_pkg::ST_WALK_M1: state_next = wssim_pkg::ST_WALK_M2;
      wssim_pkg::ST_WALK_M2: state_next = wssim_pkg::ST_WALK_M3;
      wssim_pkg::ST_WALK_M3: begin
        state_next = last_cell ? wssim_pkg::ST_MUL : wssim_pkg::ST_WALK_ADDR;
      end
      wssim_pkg::ST_MUL: begin
        if (mul_ph) begin
          if (step == wssim_pkg::MS_NSAB_HI) begin
            state_next = wssim_pkg::ST_CALC0;
          end else if (step == wssim_pkg::MS_DEN_HH) begin
            state_next = wssim_pkg::ST_DIV_CHK;
          end
        end
      end
      wssim_pkg::ST_CALC0: state_next = wssim_pkg::ST_CALC1;
      wssim_pkg::ST_CALC1: state_next = wssim_pkg::ST_CALC2;
      wssim_pkg::ST_CALC2: state_next = wssim_pkg::ST_MUL;
      wssim_pkg::ST_DIV_CHK: begin
        state_next = (den == '0 || num >= den) ? wssim_pkg::ST_FINISH : wssim_pkg::ST_DIV;
      end
      wssim_pkg::ST_DIV: begin
        if (div_cnt == wssim_pkg::DIV_STEPS - 4'd1) begin
          state_next = wssim_pkg::ST_FINISH;
        end
      end
      wssim_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = wssim_pkg::ST_IDLE;
        end
      end
      default: state_next = wssim_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operand select
  always_comb begin
    in_ready = (state == wssim_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      wssim_pkg::ST_WALK_M0: begin
        mul_a = 32'(px_a);
        mul_b = 32'(px_a);
      end
      wssim_pkg::ST_WALK_M1: begin
        mul_a = 32'(px_b);
        mul_b = 32'(px_b);
      end
      wssim_pkg::ST_WALK_M2: begin
        mul_a = 32'(px_a);
        mul_b = 32'(px_b);
      end
      wssim_pkg::ST_MUL: begin
        case (step)
          wssim_pkg::MS_SQ_N:    begin mul_a = 32'(n);             mul_b = 32'(n);       end
          wssim_pkg::MS_C1_LO:   begin mul_a = stab_c1[31:0];      mul_b = nn[31:0];     end
          wssim_pkg::MS_C1_HI:   begin mul_a = 32'(stab_c1[39:32]); mul_b = nn[31:0];    end
          wssim_pkg::MS_C2_LO:   begin mul_a = stab_c2[31:0];      mul_b = nn[31:0];     end
          wssim_pkg::MS_C2_HI:   begin mul_a = 32'(stab_c2[39:32]); mul_b = nn[31:0];    end
          wssim_pkg::MS_SA_SB:   begin mul_a = 32'(sa);            mul_b = 32'(sb);      end
          wssim_pkg::MS_SA_SA:   begin mul_a = 32'(sa);            mul_b = 32'(sa);      end
          wssim_pkg::MS_SB_SB:   begin mul_a = 32'(sb);            mul_b = 32'(sb);      end
          wssim_pkg::MS_NSAA_LO: begin mul_a = 32'(n);             mul_b = saa64[31:0];  end
          wssim_pkg::MS_NSAA_HI: begin mul_a = 32'(n);             mul_b = saa64[63:32]; end
          wssim_pkg::MS_NSBB_LO: begin mul_a = 32'(n);             mul_b = sbb64[31:0];  end
          wssim_pkg::MS_NSBB_HI: begin mul_a = 32'(n);             mul_b = sbb64[63:32]; end
          wssim_pkg::MS_NSAB_LO: begin mul_a = 32'(n);             mul_b = sab64[31:0];  end
          wssim_pkg::MS_NSAB_HI: begin mul_a = 32'(n);             mul_b = sab64[63:32]; end
          wssim_pkg::MS_NUM_LL:  begin mul_a = f1n[31:0];          mul_b = f2n[31:0];    end
          wssim_pkg::MS_NUM_LH:  begin mul_a = f1n[31:0];          mul_b = f2n[63:32];   end
          wssim_pkg::MS_NUM_HL:  begin mul_a = f1n[63:32];         mul_b = f2n[31:0];    end
          wssim_pkg::MS_NUM_HH:  begin mul_a = f1n[63:32];         mul_b = f2n[63:32];   end
          wssim_pkg::MS_DEN_LL:  begin mul_a = f1d[31:0];          mul_b = f2d[31:0];    end
          wssim_pkg::MS_DEN_LH:  begin mul_a = f1d[31:0];          mul_b = f2d[63:32];   end
          wssim_pkg::MS_DEN_HL:  begin mul_a = f1d[63:32];         mul_b = f2d[31:0];    end
          wssim_pkg::MS_DEN_HH:  begin mul_a = f1d[63:32];         mul_b = f2d[63:32];   end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Line store: one write port on input transfers, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (state == wssim_pkg::ST_IDLE && in_valid
        && in_item.operation == wssim_pkg::OP_PIXEL) begin
      store_mem[wr_addr] <= {in_item.sample_b[SAMPLE_BITS-1:0],
                             in_item.sample_a[SAMPLE_BITS-1:0]};
    end
    if (state == wssim_pkg::ST_WALK_ADDR) begin
      rd_data <= store_mem[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= wssim_pkg::RST_IMAGE_WIDTH;
      image_height   <= wssim_pkg::RST_IMAGE_HEIGHT;
      patch_radius   <= wssim_pkg::RST_PATCH_RADIUS;
      stab_c1        <= wssim_pkg::RST_STAB_C1;
      stab_c2        <= wssim_pkg::RST_STAB_C2;
      clamp_negative <= wssim_pkg::RST_CLAMP_NEGATIVE;
    end else if (cfg_write) begin
      case (cfg_index)
        wssim_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[10:0];
        wssim_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[10:0];
        wssim_pkg::REG_PATCH_RADIUS:   patch_radius   <= cfg_data[1:0];
        wssim_pkg::REG_STAB_C1:        stab_c1        <= cfg_data[39:0];
        wssim_pkg::REG_STAB_C2:        stab_c2        <= cfg_data[39:0];
        wssim_pkg::REG_CLAMP_NEGATIVE: clamp_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier, product always registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wssim_pkg::ST_IDLE;
      in_pos     <= '0;
      out_pos    <= '0;
      items_seen <= '0;
      out_valid  <= 1'b0;
      step       <= wssim_pkg::MS_SQ_N;
      mul_ph     <= 1'b0;
      div_cnt    <= '0;
    end else begin
      state <= state_next;
      // Load a finished result, else drop valid once the result transfers
      if (state == wssim_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        wssim_pkg::ST_IDLE: begin
          if (in_valid) begin
            if (in_item.operation == wssim_pkg::OP_DRAIN) begin
              in_pos <= in_norm;
            end else begin
              in_pos     <= adv_pos(in_norm, eff_w, eff_h);
              items_seen <= items_seen + IW'(1);
            end
          end
        end
        wssim_pkg::ST_WALK_INIT: begin
          out_pos <= norm_pos(out_pos, eff_w, eff_h);
          step    <= wssim_pkg::MS_SQ_N;
          mul_ph  <= 1'b0;
        end
        wssim_pkg::ST_MUL: begin
          mul_ph <= !mul_ph;
          if (mul_ph) begin
            step <= wssim_pkg::mul_step_t'(5'(step) + 5'd1);
          end
        end
        wssim_pkg::ST_DIV_CHK: begin
          div_cnt <= '0;
        end
        wssim_pkg::ST_DIV: begin
          div_cnt <= div_cnt + 4'd1;
        end
        wssim_pkg::ST_FINISH: begin
          if (out_free) begin
            out_pos    <= adv_pos(out_pos, eff_w, eff_h);
            items_seen <= items_seen - IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      wssim_pkg::ST_WALK_INIT: begin
        dx  <= -r_s;
        dy  <= -r_s;
        n   <= '0;
        sa  <= '0;
        sb  <= '0;
        saa <= '0;
        sbb <= '0;
        sab <= '0;
      end
      wssim_pkg::ST_WALK_ADDR, wssim_pkg::ST_WALK_M3: begin
        if (state == wssim_pkg::ST_WALK_M3) begin
          sab <= sab + S2_W'(prod);
        end
        // Step to the next cell of the square unless this one needs a read
        if (state == wssim_pkg::ST_WALK_M3 || !cell_ok) begin
          if (dx == r_s) begin
            dx <= -r_s;
            dy <= dy + DW'(1);
          end else begin
            dx <= dx + DW'(1);
          end
        end
      end
      wssim_pkg::ST_WALK_M0: begin
        n  <= n + CNT_W'(1);
        sa <= sa + S1_W'(px_a);
        sb <= sb + S1_W'(px_b);
      end
      wssim_pkg::ST_WALK_M1: saa <= saa + S2_W'(prod);
      wssim_pkg::ST_WALK_M2: sbb <= sbb + S2_W'(prod);
      wssim_pkg::ST_MUL: begin
        if (mul_ph) begin
          case (step)
            wssim_pkg::MS_SQ_N:    nn   <= prod;
            wssim_pkg::MS_C1_LO:   c1n  <= prod;
            wssim_pkg::MS_C1_HI:   c1n  <= c1n + {prod[31:0], 32'd0};
            wssim_pkg::MS_C2_LO:   c2n  <= prod;
            wssim_pkg::MS_C2_HI:   c2n  <= c2n + {prod[31:0], 32'd0};
            wssim_pkg::MS_SA_SB:   q    <= prod;
            wssim_pkg::MS_SA_SA:   sasa <= prod;
            wssim_pkg::MS_SB_SB:   sbsb <= prod;
            wssim_pkg::MS_NSAA_LO: nsaa <= prod;
            wssim_pkg::MS_NSAA_HI: nsaa <= nsaa + {prod[31:0], 32'd0};
            wssim_pkg::MS_NSBB_LO: nsbb <= prod;
            wssim_pkg::MS_NSBB_HI: nsbb <= nsbb + {prod[31:0], 32'd0};
            wssim_pkg::MS_NSAB_LO: p    <= prod;
            wssim_pkg::MS_NSAB_HI: p    <= p + {prod[31:0], 32'd0};
            wssim_pkg::MS_NUM_LL:  num  <= {64'd0, prod};
            wssim_pkg::MS_NUM_LH,
            wssim_pkg::MS_NUM_HL:  num  <= num + {32'd0, prod, 32'd0};
            wssim_pkg::MS_NUM_HH:  num  <= num + {prod, 64'd0};
            wssim_pkg::MS_DEN_LL:  den  <= {64'd0, prod};
            wssim_pkg::MS_DEN_LH,
            wssim_pkg::MS_DEN_HL:  den  <= den + {32'd0, prod, 32'd0};
            wssim_pkg::MS_DEN_HH:  den  <= den + {prod, 64'd0};
            default: ;
          endcase
        end
      end
      wssim_pkg::ST_CALC0: begin
        f1n     <= (q << 9) + c1n;
        va      <= nsaa - sasa;
        vb      <= nsbb - sbsb;
        pos_cov <= p >= q;
        diff    <= (p >= q) ? (p - q) : (q - p);
      end
      wssim_pkg::ST_CALC1: begin
        f1d  <= ((sasa + sbsb) << 8) + c1n;
        f2d  <= ((va + vb) << 8) + c2n;
        diff <= diff << 9;
      end
      wssim_pkg::ST_CALC2: begin
        // Covariance term may go negative; keep its magnitude and a sign
        if (pos_cov) begin
          f2n <= diff + c2n;
          neg <= 1'b0;
        end else if (diff > c2n) begin
          f2n <= diff - c2n;
          neg <= 1'b1;
        end else begin
          f2n <= c2n - diff;
          neg <= 1'b0;
        end
      end
      wssim_pkg::ST_DIV_CHK: begin
        quo <= '0;
        if (den == '0) begin
          mag <= wssim_pkg::ONE_Q14;
          neg <= 1'b0;
        end else if (num >= den) begin
          mag <= wssim_pkg::ONE_Q14;
        end
      end
      wssim_pkg::ST_DIV: begin
        num <= div_ge ? (num_sh - den) : num_sh;
        quo <= quo_next;
        if (div_cnt == wssim_pkg::DIV_STEPS - 4'd1) begin
          // Round half up on the extra quotient bit
          mag <= 15'((16'(quo_next) + 16'd1) >> 1);
        end
      end
      wssim_pkg::ST_FINISH: begin
        if (out_free) begin
          if (neg && mag != '0 && !clamp_negative) begin
            out_item.ssim_value <= $signed(16'd0 - {1'b0, mag});
          end else if (neg && mag != '0) begin
            out_item.ssim_value <= '0;
          end else begin
            out_item.ssim_value <= $signed({1'b0, mag});
          end
          out_item.frame_end <= (32'(out_pos.row) == 32'(eff_h) - 1)
                                && (32'(out_pos.col) == 32'(eff_w) - 1);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== bench/tb_windowed_ssim_image_compare.sv =====
`timescale 1ns / 100ps

// Scoreboard: a behavioral copy of the windowed similarity datapath. It mirrors the
// line store, the input and output raster positions and the register set. It queues
// one expected result per result-producing input.
class ssim_scoreboard;
  localparam int LINES = 8;
  localparam int MAXW  = 1024;
  localparam int MAXH  = 1024;

  bit [31:0]   line_mem [LINES*MAXW];
  int unsigned in_col, in_row, in_ln, out_col, out_row, out_ln, pending;
  bit [10:0]   width_reg, height_reg;
  bit [1:0]    radius_reg;
  bit [39:0]   c1_reg, c2_reg;
  bit          clamp_reg;
  wssim_pkg::out_item_t expected_q[$];
  int          mismatches, results_checked, pixels_taken;

  function new();
    width_reg  = wssim_pkg::RST_IMAGE_WIDTH;
    height_reg = wssim_pkg::RST_IMAGE_HEIGHT;
    radius_reg = wssim_pkg::RST_PATCH_RADIUS;
    c1_reg     = wssim_pkg::RST_STAB_C1;
    c2_reg     = wssim_pkg::RST_STAB_C2;
    clamp_reg  = wssim_pkg::RST_CLAMP_NEGATIVE;
  endfunction

  function void set_reg(logic [2:0] idx, logic [39:0] val);
    case (idx)
      wssim_pkg::REG_IMAGE_WIDTH:    width_reg  = val[10:0];
      wssim_pkg::REG_IMAGE_HEIGHT:   height_reg = val[10:0];
      wssim_pkg::REG_PATCH_RADIUS:   radius_reg = val[1:0];
      wssim_pkg::REG_STAB_C1:        c1_reg     = val;
      wssim_pkg::REG_STAB_C2:        c2_reg     = val;
      wssim_pkg::REG_CLAMP_NEGATIVE: clamp_reg  = val[0];
      default: ;
    endcase
  endfunction

  function int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > MAXW) ? MAXW : width_reg;
  endfunction

  function int unsigned eff_h();
    if (height_reg == 0) return 1;
    return (height_reg > MAXH) ? MAXH : height_reg;
  endfunction

  function void next_row(inout int unsigned col, inout int unsigned row,
                         inout int unsigned ln);
    col = 0;
    ln  = (ln + 1) % LINES;
    row = (row + 1 >= eff_h()) ? 0 : row + 1;
  endfunction

  function void wrap_pos(inout int unsigned col, inout int unsigned row,
                         inout int unsigned ln);
    if (col >= eff_w()) next_row(col, row, ln);
    if (row >= eff_h()) row = 0;
  endfunction

  // Exact window sums, the two rational factors, then a restoring divide to Q2.14.
  function wssim_pkg::out_item_t similarity();
    int unsigned w, h;
    int          rad, dy, dx, y, x, slot;
    bit [63:0]   n, sa, sb, saa, sbb, sab, a, b, nn, c1n, c2n;
    bit [63:0]   f1n, f1d, va, vb, f2d, p, q, f2n, d;
    bit [127:0]  num, den;
    bit          neg;
    int unsigned mag, quo;
    wssim_pkg::out_item_t res;
    w = eff_w();
    h = eff_h();
    rad = radius_reg;
    n = 0; sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
    neg = 0;
    wrap_pos(out_col, out_row, out_ln);
    for (dy = -rad; dy <= rad; dy++) begin
      for (dx = -rad; dx <= rad; dx++) begin
        y = int'(out_row) + dy;
        x = int'(out_col) + dx;
        if (dx * dx + dy * dy > rad * rad) continue;
        if (y < 0 || y >= int'(h) || x < 0 || x >= int'(w)) continue;
        slot = (int'(out_ln) + dy + LINES) % LINES;
        a = line_mem[slot*MAXW + x][15:0];
        b = line_mem[slot*MAXW + x][31:16];
        n++; sa += a; sb += b; saa += a * a; sbb += b * b; sab += a * b;
      end
    end
    nn  = n * n;
    c1n = c1_reg * nn;
    c2n = c2_reg * nn;
    f1n = 512 * sa * sb + c1n;
    f1d = 256 * (sa * sa + sb * sb) + c1n;
    va  = n * saa - sa * sa;
    vb  = n * sbb - sb * sb;
    f2d = 256 * (va + vb) + c2n;
    p   = n * sab;
    q   = sa * sb;
    if (p >= q) begin
      f2n = 512 * (p - q) + c2n;
    end else begin
      d = 512 * (q - p);
      if (d > c2n) begin
        f2n = d - c2n;
        neg = 1;
      end else begin
        f2n = c2n - d;
      end
    end
    num = 128'(f1n) * 128'(f2n);
    den = 128'(f1d) * 128'(f2d);
    if (den == 0) begin
      mag = wssim_pkg::ONE_Q14;
      neg = 0;
    end else if (num >= den) begin
      mag = wssim_pkg::ONE_Q14;
    end else begin
      quo = 0;
      for (int i = 0; i < wssim_pkg::DIV_STEPS; i++) begin
        num = num << 1;
        quo = quo << 1;
        if (num >= den) begin
          num = num - den;
          quo |= 1;
        end
      end
      mag = (quo + 1) >> 1;
    end
    if (mag == 0) neg = 0;
    if (neg && clamp_reg) begin
      mag = 0;
      neg = 0;
    end
    res.ssim_value = neg ? 16'(-int'(mag)) : 16'(mag);
    res.frame_end  = (out_row == h - 1 && out_col == w - 1);
    if (out_col + 1 >= w) next_row(out_col, out_row, out_ln);
    else out_col++;
    pending--;
    return res;
  endfunction

  // Note one input transfer; queue its result if it produces one.
  function void note_input(wssim_pkg::in_item_t it);
    int unsigned w, lag;
    w = eff_w();
    lag = radius_reg * w + radius_reg;
    wrap_pos(in_col, in_row, in_ln);
    if (it.operation == wssim_pkg::OP_PIXEL) begin
      line_mem[in_ln*MAXW + in_col] = {it.sample_b, it.sample_a};
      if (in_col + 1 >= w) next_row(in_col, in_row, in_ln);
      else in_col++;
      pending++;
      pixels_taken++;
      if (pending > lag) expected_q.push_back(similarity());
    end else if (in_col == 0 && in_row == 0 && pending > 0) begin
      expected_q.push_back(similarity());
    end
  endfunction

  function void check(wssim_pkg::out_item_t got);
    wssim_pkg::out_item_t want;
    results_checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result ssim=%0d end=%0b", $realtime,
                 got.ssim_value, got.frame_end);
      return;
    end
    want = expected_q.pop_front();
    if (got.ssim_value !== want.ssim_value || got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d: expected ssim=%0d end=%0b, got ssim=%0d end=%0b",
                 $realtime, results_checked, want.ssim_value, want.frame_end,
                 got.ssim_value, got.frame_end);
    end
  endfunction
endclass

module tb_windowed_ssim_image_compare;

  // Each result costs its walk, multiplies and divide plus output stalls; with gaps and
  // under a thousand results this stays far below the limit.
  localparam int CYCLE_LIMIT = 6_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  wssim_pkg::in_item_t  in_item;
  logic        out_valid;
  logic        out_ready;
  wssim_pkg::out_item_t out_item;
  logic        cfg_write;
  logic [wssim_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wssim_pkg::CFG_DATA_W-1:0]  cfg_data;

  ssim_scoreboard sb = new();
  bit steady;     // no idling on either side while set
  int cycles = 0;
  int phases;

  windowed_ssim_image_compare u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_ssim_image_compare regression: fail");
      $finish;
    end
  end

  // Result side: check every transfer, stall ready about a quarter of the time.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check(out_item);
      out_ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // Drive one input item; valid stays high afterward so back-to-back transfers
  // never lower and raise it in the same step.
  task automatic send(logic op, logic [15:0] a, logic [15:0] b);
    wssim_pkg::in_item_t it;
    it.operation = op;
    it.sample_a  = a;
    it.sample_b  = b;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Flush what is still pending, then hold until every result has arrived.
  task automatic drain_all();
    while (sb.pending > 0) send(wssim_pkg::OP_DRAIN, $urandom, $urandom);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write the full register set while the block is idle.
  task automatic write_regs(logic [10:0] w, logic [10:0] h, logic [1:0] r,
                            logic [39:0] c1, logic [39:0] c2, logic cl);
    logic [39:0] vals [6];
    logic [2:0]  idx  [6];
    vals = '{40'(w), 40'(h), 40'(r), c1, c2, 40'(cl)};
    idx  = '{wssim_pkg::REG_IMAGE_WIDTH, wssim_pkg::REG_IMAGE_HEIGHT,
             wssim_pkg::REG_PATCH_RADIUS, wssim_pkg::REG_STAB_C1,
             wssim_pkg::REG_STAB_C2, wssim_pkg::REG_CLAMP_NEGATIVE};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
    phases++;
  endtask

  function automatic logic [39:0] pick_const();
    case ($urandom_range(0, 4))
      0: return 40'd0;
      1: return 40'd1;
      2: return 40'hFF_FFFF_FFFF;
      3: return 40'($urandom_range(1, 100000));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // A pixel pair with mostly related content: equal, near, unrelated, inverted or extremes.
  task automatic send_pixel();
    logic [15:0] a, b;
    int mode;
    a = $urandom;
    mode = $urandom_range(0, 9);
    if (mode < 4)      b = a + 16'($urandom_range(0, 600)) - 16'd300;
    else if (mode < 6) b = a;
    else if (mode < 8) b = $urandom;
    else if (mode < 9) b = ~a;
    else begin
      a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    send(wssim_pkg::OP_PIXEL, a, b);
  endtask

  task automatic random_frames(int unsigned w, int unsigned h, int frames);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
    eh = (h == 0) ? 1 : (h > 1024 ? 1024 : h);
    for (int f = 0; f < frames; f++) begin
      for (int k = 0; k < ew * eh; k++) begin
        // Stray drain mid-frame: must be dropped.
        if (k > 0 && $urandom_range(0, 99) < 4)
          send(wssim_pkg::OP_DRAIN, $urandom, $urandom);
        send_pixel();
      end
    end
    drain_all();
  endtask

  initial begin
    int unsigned w, h;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    phases    = 0;
    steady    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Flat and zero windows with zero constants give exactly one; then full-scale
    // opposite pixels.
    write_regs(11'd4, 11'd3, 2'd1, 40'd0, 40'd0, 1'b0);
    for (int k = 0; k < 12; k++) begin
      if (k == 6) send(wssim_pkg::OP_DRAIN, 16'hFFFF, 16'hFFFF);
      if (k < 4)       send(wssim_pkg::OP_PIXEL, 16'h0000, 16'h0000);
      else if (k < 8)  send(wssim_pkg::OP_PIXEL, (k % 2) ? 16'hFFFF : 16'h0000,
                            (k % 2) ? 16'h0000 : 16'hFFFF);
      else             send(wssim_pkg::OP_PIXEL, 16'hFFFF, 16'hFFFF);
    end
    drain_all();

    // Anti-correlated ramp: negative similarity, clamped and then kept.
    for (int cl = 1; cl >= 0; cl--) begin
      write_regs(11'd5, 11'd2, 2'd2, 40'd1, 40'd1, 1'(cl));
      for (int k = 0; k < 10; k++)
        send(wssim_pkg::OP_PIXEL, 16'(k * 7000), 16'hFFFF - 16'(k * 7000));
      drain_all();
    end

    // Long single row, then a tall single column at the widest radius.
    write_regs(11'd250, 11'd1, 2'd0, pick_const(), pick_const(), 1'b0);
    random_frames(250, 1, 1);
    write_regs(11'd1, 11'd150, 2'd3, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
    random_frames(1, 150, 1);

    // Random small images until enough pixels went through.
    sb.pixels_taken = 0;
    for (int ph = 0; sb.pixels_taken < 250; ph++) begin
      steady = (ph == 3 || ph == 4);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      write_regs(11'(w), 11'(h), 2'($urandom_range(0, 3)), pick_const(), pick_const(),
                 1'($urandom_range(0, 1)));
      random_frames(w, h, $urandom_range(1, 2));
    end
    steady = 1'b0;

    repeat (400) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.mismatches++;
      $display("%0d expected results never arrived", sb.expected_q.size());
    end
    $display("Covered %0d register settings, %0d results checked, %0d mismatches.",
             phases, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("windowed_ssim_image_compare regression: pass");
    else
      $display("windowed_ssim_image_compare regression: fail");
    $finish;
  end

endmodule
